### rtl/aat_pkg.sv
// Shared types, widths and register codes for the box transform pipeline.
// No dependencies; every other file in the block refers to this package.
package aat_pkg;

	// coordinate and weight formats
	localparam int COORD_WIDTH    = 32;
	localparam int WEIGHT_WIDTH   = 16;
	localparam int AXES           = 3;

	// derived widths: exact products and sums, no truncation before rounding
	localparam int SUM_WIDTH      = COORD_WIDTH + 1;
	localparam int PROD_WIDTH     = SUM_WIDTH + WEIGHT_WIDTH;
	localparam int ACC_WIDTH      = PROD_WIDTH + 2;
	localparam int RES_WIDTH      = ACC_WIDTH + 2;
	localparam int FRAC_SHIFT     = WEIGHT_WIDTH - 1;
	localparam int WREG_WIDTH     = AXES * WEIGHT_WIDTH;
	localparam int CFG_DATA_WIDTH = (WREG_WIDTH > COORD_WIDTH) ? WREG_WIDTH : COORD_WIDTH;
	localparam int CFG_IDX_WIDTH  = 3;

	typedef logic signed [COORD_WIDTH-1:0]  coord_t;
	typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
	typedef logic signed [SUM_WIDTH-1:0]    sum_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic signed [RES_WIDTH-1:0]    res_t;
	typedef logic [WREG_WIDTH-1:0]          wreg_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		REG_WEIGHTS_X = 3'd0,
		REG_WEIGHTS_Y = 3'd1,
		REG_WEIGHTS_Z = 3'd2,
		REG_OFFSET_X  = 3'd3,
		REG_OFFSET_Y  = 3'd4,
		REG_OFFSET_Z  = 3'd5
	} cfg_reg_t;

	// box as two corners
	typedef struct packed {
		coord_t [AXES-1:0] lo;
		coord_t [AXES-1:0] hi;
	} box_t;

	// doubled center and doubled extent
	typedef struct packed {
		sum_t [AXES-1:0] s;
		sum_t [AXES-1:0] d;
	} sd_t;

	// products, indexed [output][input]
	typedef struct packed {
		prod_t [AXES-1:0][AXES-1:0] ps;
		prod_t [AXES-1:0][AXES-1:0] pd;
	} prod_set_t;

	// mapped center and extent per output axis
	typedef struct packed {
		acc_t [AXES-1:0] c;
		acc_t [AXES-1:0] e;
	} acc_set_t;

	// rounded-up corner sums before scaling
	typedef struct packed {
		res_t [AXES-1:0] lo;
		res_t [AXES-1:0] hi;
	} res_set_t;

	typedef weight_t [AXES-1:0][AXES-1:0] mat_t;
	typedef coord_t [AXES-1:0]            offs_t;

	// stage enables from the top-level flow control
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

endpackage

### rtl/aat_prep.sv
// Stage 1: doubled center (lo + hi) and doubled extent (hi - lo) per axis.
// Depends on aat_pkg.
module aat_prep (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  aat_pkg::box_t box_in,
	output logic          v_s1,
	output aat_pkg::sd_t  sd_s1
);

	aat_pkg::sd_t sd_next;

	// form sum and difference with one guard bit
	always_comb begin
		for (int i = 0; i < aat_pkg::AXES; i++) begin
			sd_next.s[i] = aat_pkg::sum_t'(box_in.lo[i]) + aat_pkg::sum_t'(box_in.hi[i]);
			sd_next.d[i] = aat_pkg::sum_t'(box_in.hi[i]) - aat_pkg::sum_t'(box_in.lo[i]);
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	// load payload
	always_ff @(posedge clk) begin
		if (en && v_in) begin
			sd_s1 <= sd_next;
		end
	end

endmodule

### rtl/aat_mul.sv
// Stage 2: weight products of center and extent, one multiplier per term.
// Depends on aat_pkg.
module aat_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  aat_pkg::sd_t       sd_in,
	input  aat_pkg::mat_t      mat,
	output logic               v_s2,
	output aat_pkg::prod_set_t prod_s2
);

	aat_pkg::prod_set_t prod_next;

	// multiply each weight by center and extent terms
	always_comb begin
		for (int j = 0; j < aat_pkg::AXES; j++) begin
			for (int i = 0; i < aat_pkg::AXES; i++) begin
				prod_next.ps[j][i] = aat_pkg::prod_t'($signed(mat[j][i]) * $signed(sd_in.s[i]));
				prod_next.pd[j][i] = aat_pkg::prod_t'($signed(mat[j][i]) * $signed(sd_in.d[i]));
			end
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_in;
		end
	end

	// load payload
	always_ff @(posedge clk) begin
		if (en && v_in) begin
			prod_s2 <= prod_next;
		end
	end

endmodule

### rtl/aat_acc.sv
// Stage 3: mapped center (offset plus weighted sum) and summed absolute extent.
// Depends on aat_pkg.
module aat_acc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               v_in,
	input  aat_pkg::prod_set_t prod_in,
	input  aat_pkg::offs_t     offs,
	output logic               v_s3,
	output aat_pkg::acc_set_t  acc_s3
);

	aat_pkg::acc_set_t acc_next;
	aat_pkg::acc_t     pd_ext;

	// sum the three terms per output axis
	always_comb begin
		pd_ext = '0;
		for (int j = 0; j < aat_pkg::AXES; j++) begin
			acc_next.c[j] = aat_pkg::acc_t'($signed(offs[j])) <<< aat_pkg::FRAC_SHIFT;
			acc_next.e[j] = '0;
			for (int i = 0; i < aat_pkg::AXES; i++) begin
				acc_next.c[j] = acc_next.c[j] + aat_pkg::acc_t'($signed(prod_in.ps[j][i]));
				pd_ext        = aat_pkg::acc_t'($signed(prod_in.pd[j][i]));
				acc_next.e[j] = acc_next.e[j] + (pd_ext[aat_pkg::ACC_WIDTH-1] ? -pd_ext : pd_ext);
			end
		end
	end

	// advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
		end
	end

	// load payload
	always_ff @(posedge clk) begin
		if (en && v_in) begin
			acc_s3 <= acc_next;
		end
	end

endmodule

### rtl/aat_round.sv
// Stages 4 and 5: corners as center -/+ extent with round-half-up, then
// scale back to the coordinate format and saturate. Depends on aat_pkg.
module aat_round (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en_s4,
	input  logic              en_s5,
	input  logic              v_in,
	input  aat_pkg::acc_set_t acc_in,
	output logic              v_s4,
	output logic              v_s5,
	output aat_pkg::box_t     box_s5
);

	localparam aat_pkg::res_t RND     = aat_pkg::res_t'(1) <<< (aat_pkg::FRAC_SHIFT - 1);
	localparam aat_pkg::res_t RES_MAX =
		aat_pkg::res_t'({1'b0, {(aat_pkg::COORD_WIDTH-1){1'b1}}});
	localparam aat_pkg::res_t RES_MIN = ~RES_MAX;

	aat_pkg::res_set_t res_next;
	aat_pkg::res_set_t res_s4;
	aat_pkg::box_t     box_next;
	aat_pkg::res_t     lo_sh;
	aat_pkg::res_t     hi_sh;

	// form both corners with the rounding bias
	always_comb begin
		for (int j = 0; j < aat_pkg::AXES; j++) begin
			res_next.lo[j] = aat_pkg::res_t'($signed(acc_in.c[j]))
				- aat_pkg::res_t'($signed(acc_in.e[j])) + RND;
			res_next.hi[j] = aat_pkg::res_t'($signed(acc_in.c[j]))
				+ aat_pkg::res_t'($signed(acc_in.e[j])) + RND;
		end
	end

	// drop fraction bits and clamp to the coordinate range
	always_comb begin
		lo_sh = '0;
		hi_sh = '0;
		for (int j = 0; j < aat_pkg::AXES; j++) begin
			lo_sh = $signed(res_s4.lo[j]) >>> aat_pkg::FRAC_SHIFT;
			hi_sh = $signed(res_s4.hi[j]) >>> aat_pkg::FRAC_SHIFT;
			if (lo_sh > RES_MAX) begin
				box_next.lo[j] = aat_pkg::coord_t'(RES_MAX);
			end else if (lo_sh < RES_MIN) begin
				box_next.lo[j] = aat_pkg::coord_t'(RES_MIN);
			end else begin
				box_next.lo[j] = aat_pkg::coord_t'(lo_sh);
			end
			if (hi_sh > RES_MAX) begin
				box_next.hi[j] = aat_pkg::coord_t'(RES_MAX);
			end else if (hi_sh < RES_MIN) begin
				box_next.hi[j] = aat_pkg::coord_t'(RES_MIN);
			end else begin
				box_next.hi[j] = aat_pkg::coord_t'(hi_sh);
			end
		end
	end

	// advance valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= v_in;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// load payloads
	always_ff @(posedge clk) begin
		if (en_s4 && v_in) begin
			res_s4 <= res_next;
		end
		if (en_s5 && v_s4) begin
			box_s5 <= box_next;
		end
	end

endmodule

### rtl/aabb_affine_transform.sv
// An accepted input beat passes the registered stages s1 (prep), s2 (mul), s3 (acc), s4 and s5 (round).
// Throughput: one box per cycle unless out_stall holds; each stage takes a beat, none iterates.
// Each stage holds under output stall and empty stages fill in (bubble collapse).
// Reset clears all stage valids and loads the identity matrix with zero offset.
// Top level: configuration registers, stage flow control and the output beat.
// Depends on aat_pkg, aat_prep, aat_mul, aat_acc and aat_round.
module aabb_affine_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [aat_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [aat_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	// input box
	input  logic                                in_valid,
	output logic                                in_stall,
	input  aat_pkg::coord_t                     lo_x,
	input  aat_pkg::coord_t                     lo_y,
	input  aat_pkg::coord_t                     lo_z,
	input  aat_pkg::coord_t                     hi_x,
	input  aat_pkg::coord_t                     hi_y,
	input  aat_pkg::coord_t                     hi_z,
	// output box
	output logic                                out_valid,
	input  logic                                out_stall,
	output aat_pkg::coord_t                     new_lo_x,
	output aat_pkg::coord_t                     new_lo_y,
	output aat_pkg::coord_t                     new_lo_z,
	output aat_pkg::coord_t                     new_hi_x,
	output aat_pkg::coord_t                     new_hi_y,
	output aat_pkg::coord_t                     new_hi_z
);

	aat_pkg::wreg_t [aat_pkg::AXES-1:0] wreg_q;
	aat_pkg::offs_t                     offs_q;
	aat_pkg::mat_t                      mat;
	aat_pkg::box_t                      box_in;
	aat_pkg::box_t                      box_out;
	aat_pkg::sd_t                       sd_s1;
	aat_pkg::prod_set_t                 prod_s2;
	aat_pkg::acc_set_t                  acc_s3;
	aat_pkg::stage_en_t                 en;
	logic                               v_s1;
	logic                               v_s2;
	logic                               v_s3;
	logic                               v_s4;
	logic                               v_s5;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < aat_pkg::AXES; j++) begin
				wreg_q[j] <= aat_pkg::wreg_t'(1) << (aat_pkg::WEIGHT_WIDTH - 2
					+ j * aat_pkg::WEIGHT_WIDTH);
				offs_q[j] <= '0;
			end
		end else if (cfg_wr_en) begin
			unique case (aat_pkg::cfg_reg_t'(cfg_index))
				aat_pkg::REG_WEIGHTS_X: wreg_q[0] <= cfg_data[aat_pkg::WREG_WIDTH-1:0];
				aat_pkg::REG_WEIGHTS_Y: wreg_q[1] <= cfg_data[aat_pkg::WREG_WIDTH-1:0];
				aat_pkg::REG_WEIGHTS_Z: wreg_q[2] <= cfg_data[aat_pkg::WREG_WIDTH-1:0];
				aat_pkg::REG_OFFSET_X:  offs_q[0] <= cfg_data[aat_pkg::COORD_WIDTH-1:0];
				aat_pkg::REG_OFFSET_Y:  offs_q[1] <= cfg_data[aat_pkg::COORD_WIDTH-1:0];
				aat_pkg::REG_OFFSET_Z:  offs_q[2] <= cfg_data[aat_pkg::COORD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// unpack weight fields, [output][input]
	always_comb begin
		for (int j = 0; j < aat_pkg::AXES; j++) begin
			for (int i = 0; i < aat_pkg::AXES; i++) begin
				mat[j][i] = wreg_q[j][i*aat_pkg::WEIGHT_WIDTH +: aat_pkg::WEIGHT_WIDTH];
			end
		end
	end

	// a stage loads when it is empty or the next stage loads
	always_comb begin
		en.s5 = !v_s5 || !out_stall;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign in_stall = !en.s1;

	assign box_in.lo[0] = lo_x;
	assign box_in.lo[1] = lo_y;
	assign box_in.lo[2] = lo_z;
	assign box_in.hi[0] = hi_x;
	assign box_in.hi[1] = hi_y;
	assign box_in.hi[2] = hi_z;

	aat_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en.s1),
		.v_in   (in_valid),
		.box_in (box_in),
		.v_s1   (v_s1),
		.sd_s1  (sd_s1)
	);

	aat_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en.s2),
		.v_in    (v_s1),
		.sd_in   (sd_s1),
		.mat     (mat),
		.v_s2    (v_s2),
		.prod_s2 (prod_s2)
	);

	aat_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en.s3),
		.v_in    (v_s2),
		.prod_in (prod_s2),
		.offs    (offs_q),
		.v_s3    (v_s3),
		.acc_s3  (acc_s3)
	);

	aat_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.en_s4  (en.s4),
		.en_s5  (en.s5),
		.v_in   (v_s3),
		.acc_in (acc_s3),
		.v_s4   (v_s4),
		.v_s5   (v_s5),
		.box_s5 (box_out)
	);

	// output beat
	assign out_valid = v_s5;
	assign new_lo_x  = box_out.lo[0];
	assign new_lo_y  = box_out.lo[1];
	assign new_lo_z  = box_out.lo[2];
	assign new_hi_x  = box_out.hi[0];
	assign new_hi_y  = box_out.hi[1];
	assign new_hi_z  = box_out.hi[2];

endmodule

### dv/tb_aabb_affine_transform.sv
// Self-checking bench for aabb_affine_transform: directed boxes, then random boxes
// under a series of matrix and offset settings, checked beat by beat.
// Depends on aat_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_aabb_affine_transform;

	localparam int     ROUND_SHIFT = aat_pkg::WEIGHT_WIDTH - 1;
	localparam longint HALF_LSB    = longint'(1) <<< (ROUND_SHIFT - 1);
	localparam longint COORD_MAX   = (longint'(1) <<< (aat_pkg::COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN   = -COORD_MAX - 1;
	localparam aat_pkg::coord_t MAXC = 32'sh7fff_ffff;
	localparam aat_pkg::coord_t MINC = 32'sh8000_0000;

	// indexes past the register list; writes there must change nothing
	localparam logic [aat_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_A = 3'd6;
	localparam logic [aat_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE_B = 3'd7;

	typedef enum bit {ROW_WRITE, ROW_BOX} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	typedef struct {
		row_kind_t                          kind;
		logic [aat_pkg::CFG_IDX_WIDTH-1:0]  idx;
		logic [aat_pkg::CFG_DATA_WIDTH-1:0] data;
		aat_pkg::box_t                      box;
		bit                                 known;
		aat_pkg::box_t                      want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [aat_pkg::CFG_IDX_WIDTH-1:0]  cfg_index;
	logic [aat_pkg::CFG_DATA_WIDTH-1:0] cfg_data;
	logic            in_valid;
	logic            in_stall;
	aat_pkg::coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
	logic            out_valid;
	logic            out_stall = 1'b0;
	aat_pkg::coord_t new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z;

	// local copy of the block's registers
	aat_pkg::wreg_t  weight_regs [3];
	aat_pkg::coord_t offset_regs [3];

	aat_pkg::box_t due_boxes [$];
	stim_row_t     directed_rows [$];
	int unsigned   mismatch_count = 0;
	int unsigned   burst_left = 0;

	stall_mode_t stall_mode = STALL_NONE;
	int unsigned stall_left = 0;
	logic [7:0]  stall_bits = 8'h00;

	string axis_name [3] = '{"x", "y", "z"};

	aabb_affine_transform DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.lo_x      (lo_x),
		.lo_y      (lo_y),
		.lo_z      (lo_z),
		.hi_x      (hi_x),
		.hi_y      (hi_y),
		.hi_z      (hi_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_lo_x  (new_lo_x),
		.new_lo_y  (new_lo_y),
		.new_lo_z  (new_lo_z),
		.new_hi_x  (new_hi_x),
		.new_hi_y  (new_hi_y),
		.new_hi_z  (new_hi_z)
	);

	always #6 clk = ~clk;

	function automatic aat_pkg::box_t mk_box(input aat_pkg::coord_t lx,
			input aat_pkg::coord_t ly, input aat_pkg::coord_t lz,
			input aat_pkg::coord_t hx, input aat_pkg::coord_t hy, input aat_pkg::coord_t hz);
		aat_pkg::box_t b;
		b.lo[0] = lx;
		b.lo[1] = ly;
		b.lo[2] = lz;
		b.hi[0] = hx;
		b.hi[1] = hy;
		b.hi[2] = hz;
		return b;
	endfunction

	function automatic stim_row_t put_reg(input logic [aat_pkg::CFG_IDX_WIDTH-1:0] idx,
			input logic [aat_pkg::CFG_DATA_WIDTH-1:0] data);
		stim_row_t r;
		r = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t put_box(input aat_pkg::box_t b);
		stim_row_t r;
		r = '{ROW_BOX, '0, '0, b, 1'b0, '0};
		return r;
	endfunction

	function automatic stim_row_t put_known(input aat_pkg::box_t b, input aat_pkg::box_t want);
		stim_row_t r;
		r = '{ROW_BOX, '0, '0, b, 1'b1, want};
		return r;
	endfunction

	// round half up at the weight scale, then clamp to the coordinate range
	function automatic aat_pkg::coord_t round_sat(input longint x);
		longint r;
		r = (x + HALF_LSB) >>> ROUND_SHIFT;
		if (r > COORD_MAX)
			r = COORD_MAX;
		else if (r < COORD_MIN)
			r = COORD_MIN;
		return aat_pkg::coord_t'(r);
	endfunction

	// map doubled center through the matrix, widen by |w| times doubled extent
	function automatic aat_pkg::box_t transform_box(input aat_pkg::box_t b);
		aat_pkg::box_t    r;
		longint           s [3];
		longint           d [3];
		longint           ctr, ext, wgt, prod;
		aat_pkg::coord_t  cl, ch;
		aat_pkg::weight_t wv;
		for (int i = 0; i < 3; i++) begin
			cl = b.lo[i];
			ch = b.hi[i];
			s[i] = longint'(cl) + longint'(ch);
			d[i] = longint'(ch) - longint'(cl);
		end
		for (int j = 0; j < 3; j++) begin
			ctr = longint'(offset_regs[j]) * (longint'(1) <<< ROUND_SHIFT);
			ext = 0;
			for (int i = 0; i < 3; i++) begin
				wv = weight_regs[j][i*aat_pkg::WEIGHT_WIDTH +: aat_pkg::WEIGHT_WIDTH];
				wgt = longint'(wv);
				ctr += wgt * s[i];
				prod = wgt * d[i];
				ext += (prod < 0) ? -prod : prod;
			end
			r.lo[j] = round_sat(ctr - ext);
			r.hi[j] = round_sat(ctr + ext);
		end
		return r;
	endfunction

	function automatic aat_pkg::coord_t extreme_coord();
		case ($urandom_range(0, 4))
			0: return MINC;
			1: return MAXC;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	// mostly sane boxes of modest size; some full-range, flat, inverted or extreme
	function automatic aat_pkg::box_t rand_box();
		aat_pkg::box_t   b;
		aat_pkg::coord_t ctr, half;
		int unsigned     shape;
		shape = $urandom_range(0, 9);
		for (int a = 0; a < 3; a++) begin
			ctr = aat_pkg::coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
			half = aat_pkg::coord_t'($urandom_range(0, 1 << 20));
			case (shape)
				0, 1: begin
					b.lo[a] = $urandom;
					b.hi[a] = $urandom;
				end
				7: begin
					b.lo[a] = $urandom;
					b.hi[a] = b.lo[a];
				end
				8: begin
					b.lo[a] = ctr + half;
					b.hi[a] = ctr - half;
				end
				9: begin
					b.lo[a] = extreme_coord();
					b.hi[a] = extreme_coord();
				end
				default: begin
					b.lo[a] = ctr - half;
					b.hi[a] = ctr + half;
				end
			endcase
		end
		return b;
	endfunction

	function automatic logic [aat_pkg::CFG_DATA_WIDTH-1:0] rand_weight_reg(
			input int unsigned style, input int unsigned out_axis);
		logic [aat_pkg::CFG_DATA_WIDTH-1:0] r;
		aat_pkg::weight_t                   w;
		for (int i = 0; i < 3; i++) begin
			case (style)
				0: w = $urandom;
				1: w = aat_pkg::weight_t'(int'($urandom_range(0, 32768)) - 16384);
				2: begin
					if (i == out_axis)
						w = $urandom_range(0, 1) ? 16'sh4000 : 16'shc000;
					else
						w = 16'sh0000;
				end
				default: begin
					case ($urandom_range(0, 4))
						0: w = 16'sh8000;
						1: w = 16'sh7fff;
						2: w = 16'sh0000;
						3: w = 16'shffff;
						default: w = 16'sh0001;
					endcase
				end
			endcase
			r[i*aat_pkg::WEIGHT_WIDTH +: aat_pkg::WEIGHT_WIDTH] = w;
		end
		return r;
	endfunction

	// junk in the unused high bits must be ignored
	function automatic logic [aat_pkg::CFG_DATA_WIDTH-1:0] rand_offset_data(
			input int unsigned style);
		aat_pkg::coord_t off;
		case (style)
			0: off = $urandom;
			3: off = extreme_coord();
			default: off = aat_pkg::coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
		return {16'($urandom), off};
	endfunction

	// write one register and track it; caller lowers the enable after the group
	task automatic write_reg(input logic [aat_pkg::CFG_IDX_WIDTH-1:0] idx,
			input logic [aat_pkg::CFG_DATA_WIDTH-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		if (idx <= aat_pkg::REG_WEIGHTS_Z)
			weight_regs[idx] = data[aat_pkg::WREG_WIDTH-1:0];
		else if (idx <= aat_pkg::REG_OFFSET_Z)
			offset_regs[idx - aat_pkg::REG_OFFSET_X] = data[aat_pkg::COORD_WIDTH-1:0];
	endtask

	// present one box, hold it until taken, then maybe pause the sender
	task automatic drive_box(input aat_pkg::box_t b, input bit known,
			input aat_pkg::box_t want);
		in_valid <= 1'b1;
		lo_x <= b.lo[0];
		lo_y <= b.lo[1];
		lo_z <= b.lo[2];
		hi_x <= b.hi[0];
		hi_y <= b.hi[1];
		hi_z <= b.hi[2];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		due_boxes.push_back(known ? want : transform_box(b));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// stop sending and wait for every outstanding box to come back
	task automatic drain_results();
		if (in_valid)
			in_valid <= 1'b0;
		while (due_boxes.size() != 0)
			@(posedge clk);
	endtask

	// receiver stall: switch to a random mode whenever the mode's countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 200);
			stall_bits <= $urandom;
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= stall_bits[stall_left % 8];
		endcase
	end

	// compare each output beat with the oldest pending box
	aat_pkg::box_t   due_box, got_box;
	aat_pkg::coord_t want_c, got_c;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			got_box = mk_box(new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z);
			if (due_boxes.size() == 0) begin
				$display("%0t: output beat with no box pending, got %h", $time, got_box);
				mismatch_count++;
			end else begin
				due_box = due_boxes.pop_front();
				for (int a = 0; a < 3; a++) begin
					for (int side = 0; side < 2; side++) begin
						want_c = side ? due_box.hi[a] : due_box.lo[a];
						got_c  = side ? got_box.hi[a] : got_box.lo[a];
						if (got_c !== want_c) begin
							$display("%0t: new_%s_%s expected %0d (%h) got %0d (%h)", $time,
								side ? "hi" : "lo", axis_name[a], want_c, want_c, got_c, got_c);
							mismatch_count++;
						end
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned style;
		arst_n    <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		lo_x <= '0;
		lo_y <= '0;
		lo_z <= '0;
		hi_x <= '0;
		hi_y <= '0;
		hi_z <= '0;

		// identity matrix, zero offset after reset
		weight_regs[0] = 48'h0000_0000_4000;
		weight_regs[1] = 48'h0000_4000_0000;
		weight_regs[2] = 48'h4000_0000_0000;
		foreach (offset_regs[k])
			offset_regs[k] = '0;

		directed_rows = {
			// identity: corners pass through unchanged, inverted boxes get flipped
			put_known(mk_box(0, 0, 0, 0, 0, 0), mk_box(0, 0, 0, 0, 0, 0)),
			put_known(mk_box(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC),
				mk_box(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC)),
			put_known(mk_box(MINC, MINC, MINC, MINC, MINC, MINC),
				mk_box(MINC, MINC, MINC, MINC, MINC, MINC)),
			put_known(mk_box(MINC, MINC, MINC, MAXC, MAXC, MAXC),
				mk_box(MINC, MINC, MINC, MAXC, MAXC, MAXC)),
			put_known(mk_box(32'sh0001_0000, 32'sh0002_8000, MAXC,
					32'shffff_0000, 32'shfffd_8000, MINC),
				mk_box(32'shffff_0000, 32'shfffd_8000, MINC,
					32'sh0001_0000, 32'sh0002_8000, MAXC)),
			put_box(mk_box(32'shfffc_8000, 32'sh0000_0001, 32'sh1234_5678,
				32'sh0003_0000, 32'sh0000_0002, 32'sh2345_6789)),
			put_box(mk_box(-1, 1, 3, 0, 2, 5)),
			// extreme weights, offsets with junk in the unused high bits, spare indexes
			put_reg(aat_pkg::REG_WEIGHTS_X, 48'h7fff_8000_7fff),
			put_reg(aat_pkg::REG_WEIGHTS_Y, 48'h8000_8000_8000),
			put_reg(aat_pkg::REG_WEIGHTS_Z, 48'h7fff_7fff_7fff),
			put_reg(aat_pkg::REG_OFFSET_X, 48'ha5a5_7fff_ffff),
			put_reg(aat_pkg::REG_OFFSET_Y, 48'hffff_8000_0000),
			put_reg(aat_pkg::REG_OFFSET_Z, 48'h0000_0001_0000),
			put_reg(REG_SPARE_A, 48'hffff_ffff_ffff),
			put_reg(REG_SPARE_B, 48'h0000_0000_0000),
			put_known(mk_box(0, 0, 0, 0, 0, 0),
				mk_box(MAXC, MINC, 32'sh0001_0000, MAXC, MINC, 32'sh0001_0000)),
			put_box(mk_box(MINC, MINC, MINC, MAXC, MAXC, MAXC)),
			put_box(mk_box(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC)),
			put_box(mk_box(MAXC, MAXC, MAXC, MINC, MINC, MINC)),
			put_box(mk_box(32'sh0000_8000, -32'sh0001_0000, 32'sh0000_0003,
				32'sh0001_8000, 32'sh0000_4000, 32'sh0000_0007)),
			// zero matrix: every box collapses onto the offset point
			put_reg(aat_pkg::REG_WEIGHTS_X, 48'h0000_0000_0000),
			put_reg(aat_pkg::REG_WEIGHTS_Y, 48'h0000_0000_0000),
			put_reg(aat_pkg::REG_WEIGHTS_Z, 48'h0000_0000_0000),
			put_reg(aat_pkg::REG_OFFSET_X, 48'hffff_8000_0000),
			put_reg(aat_pkg::REG_OFFSET_Y, 48'h0000_7fff_ffff),
			put_reg(aat_pkg::REG_OFFSET_Z, 48'h5a5a_0000_0000),
			put_known(mk_box(MINC, MAXC, 1, MAXC, MINC, -1),
				mk_box(MINC, MAXC, 0, MINC, MAXC, 0)),
			put_known(mk_box(32'sh1357_9bdf, -32'sh0246_8ace, 32'sh7654_3210,
					32'sh2468_ace0, 32'sh0fed_cba9, -32'sh0123_4567),
				mk_box(MINC, MAXC, 0, MINC, MAXC, 0)),
			// fractional weights: rounding ties show up in the low bit
			put_reg(aat_pkg::REG_WEIGHTS_X, 48'h0000_0000_2000),
			put_reg(aat_pkg::REG_WEIGHTS_Y, 48'h0000_e000_0000),
			put_reg(aat_pkg::REG_WEIGHTS_Z, 48'h1000_1000_1000),
			put_reg(aat_pkg::REG_OFFSET_X, 48'h0000_fffe_8000),
			put_reg(aat_pkg::REG_OFFSET_Y, 48'h0000_0000_0001),
			put_reg(aat_pkg::REG_OFFSET_Z, 48'h0000_0000_0000),
			put_box(mk_box(1, 3, -5, 2, 7, 9)),
			put_box(mk_box(-32'sh0000_0003, 32'sh0001_0001, MINC,
				32'sh0000_0001, 32'sh0003_0003, MAXC))
		};

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table; writes only once the pipe is empty
		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_WRITE) begin
				if (!cfg_wr_en)
					drain_results();
				write_reg(directed_rows[r].idx, directed_rows[r].data);
			end else begin
				if (cfg_wr_en)
					cfg_wr_en <= 1'b0;
				drive_box(directed_rows[r].box, directed_rows[r].known, directed_rows[r].want);
			end
		end

		// random phases, each under a fresh setting
		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			style = (phase + 1) % 4;
			write_reg(aat_pkg::REG_WEIGHTS_X, rand_weight_reg(style, 0));
			write_reg(aat_pkg::REG_WEIGHTS_Y, rand_weight_reg(style, 1));
			write_reg(aat_pkg::REG_WEIGHTS_Z, rand_weight_reg(style, 2));
			write_reg(aat_pkg::REG_OFFSET_X, rand_offset_data(style));
			write_reg(aat_pkg::REG_OFFSET_Y, rand_offset_data(style));
			write_reg(aat_pkg::REG_OFFSET_Z, rand_offset_data(style));
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
					{16'($urandom), 32'($urandom)});
			cfg_wr_en <= 1'b0;
			repeat ($urandom_range(110, 160))
				drive_box(rand_box(), 1'b0, '0);
		end

		drain_results();
		repeat (12)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
